// ===== hdl/oat_pkg.sv =====
`timescale 1ns / 1ps

package oat_pkg;

   localparam int KIND_W     = 3;
   localparam int POS_W      = 8;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int FOUND_W    = 7;
   localparam int COUNT_W    = 8;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [1:0] {
      WALK_INSERT,
      WALK_DELETE,
      WALK_SEARCH,
      WALK_READ
   } walk_mode_type;

   typedef struct packed {
      logic                capture;
      logic                init;
      walk_mode_type       mode;
      logic                rd;
      logic                shift_wr;
      logic                put;
      logic                cnt_clear;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                res_clear;
      logic                take_found;
      logic                take_read;
      logic                emit;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              pos_gt;
      logic              pos_ge;
      logic              walk;
      logic              pend;
      logic              match;
      logic              rsp_free;
   } dp_sts_type;

endpackage

// ===== hdl/oat_ram.sv =====
`timescale 1ns / 1ps

module oat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/oat_ctrl.sv =====
`timescale 1ns / 1ps

module oat_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output oat_pkg::dp_cmd_type cmd,
   input  oat_pkg::dp_sts_type sts
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_UP    = 7'b0000100,
      S_DOWN  = 7'b0001000,
      S_FIND  = 7'b0010000,
      S_FETCH = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.res_clear  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = oat_pkg::ST_OK;
            state_in       = S_DONE;
            unique case (sts.kind)
               oat_pkg::KIND_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
               end
               oat_pkg::KIND_INSERT: begin
                  priority if (sts.full) begin
                     cmd.status = oat_pkg::ST_FULL;
                  end else if (sts.pos_gt) begin
                     cmd.status = oat_pkg::ST_BADPOS;
                  end else begin
                     cmd.init = 1'b1;
                     cmd.mode = oat_pkg::WALK_INSERT;
                     state_in = S_UP;
                  end
               end
               oat_pkg::KIND_DELETE: begin
                  priority if (sts.empty) begin
                     cmd.status = oat_pkg::ST_EMPTY;
                  end else if (sts.pos_ge) begin
                     cmd.status = oat_pkg::ST_BADPOS;
                  end else begin
                     cmd.init = 1'b1;
                     cmd.mode = oat_pkg::WALK_DELETE;
                     state_in = S_DOWN;
                  end
               end
               oat_pkg::KIND_SEARCH: begin
                  if (sts.empty) begin
                     cmd.status = oat_pkg::ST_EMPTY;
                  end else begin
                     cmd.init = 1'b1;
                     cmd.mode = oat_pkg::WALK_SEARCH;
                     state_in = S_FIND;
                  end
               end
               oat_pkg::KIND_READ: begin
                  priority if (sts.empty) begin
                     cmd.status = oat_pkg::ST_EMPTY;
                  end else if (sts.pos_ge) begin
                     cmd.status = oat_pkg::ST_BADPOS;
                  end else begin
                     cmd.init = 1'b1;
                     cmd.mode = oat_pkg::WALK_READ;
                     state_in = S_FETCH;
                  end
               end
               default: begin
                  cmd.status = oat_pkg::ST_BADPOS;
               end
            endcase
         end
         S_UP: begin
            cmd.rd       = sts.walk;
            cmd.shift_wr = sts.pend;
            if (!sts.walk && !sts.pend) begin
               cmd.put        = 1'b1;
               cmd.cnt_inc    = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = oat_pkg::ST_OK;
               state_in       = S_DONE;
            end
         end
         S_DOWN: begin
            cmd.rd       = sts.walk;
            cmd.shift_wr = sts.pend;
            if (!sts.walk && !sts.pend) begin
               cmd.cnt_dec    = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = oat_pkg::ST_OK;
               state_in       = S_DONE;
            end
         end
         S_FIND: begin
            if (sts.match) begin
               cmd.take_found = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = oat_pkg::ST_OK;
               state_in       = S_DONE;
            end else begin
               cmd.rd = sts.walk;
               if (!sts.walk && !sts.pend) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = oat_pkg::ST_NOTFOUND;
                  state_in       = S_DONE;
               end
            end
         end
         S_FETCH: begin
            cmd.rd = sts.walk;
            if (sts.pend) begin
               cmd.take_read  = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = oat_pkg::ST_OK;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/oat_dpath.sv =====
`timescale 1ns / 1ps

module oat_dpath #(
   parameter int DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [oat_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [oat_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [oat_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [oat_pkg::STATUS_W-1:0]      rsp_tuser,
   input  oat_pkg::dp_cmd_type               cmd,
   output oat_pkg::dp_sts_type               sts
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > oat_pkg::POS_W) ? CW : oat_pkg::POS_W;
   localparam int FW   = (AW > oat_pkg::FOUND_W) ? AW : oat_pkg::FOUND_W;

   logic [oat_pkg::KIND_W-1:0]   kind_ff;
   logic [oat_pkg::POS_W-1:0]    pos_ff;
   logic [oat_pkg::VALUE_W-1:0]  value_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                end_ff, end_in;
   logic                         walk_ff, walk_in;
   logic                         dir_dn_ff, dir_dn_in;
   logic                         pend_ff;
   logic [AW-1:0]                pend_addr_ff;
   logic [oat_pkg::STATUS_W-1:0] status_ff;
   logic [AW-1:0]                found_ff;
   logic [oat_pkg::VALUE_W-1:0]  rdval_ff;
   logic                         rsp_valid_ff;
   logic [oat_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [oat_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [CMPW-1:0]              count_ext, pos_ext, pos_inc;
   logic [FW-1:0]                found_ext;
   logic [CW-1:0]                init_idx, init_end;
   logic                         init_walk, init_dir_dn;
   logic                         last_step;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [oat_pkg::VALUE_W-1:0]  wr_data;
   logic [oat_pkg::VALUE_W-1:0]  rd_data;

   assign count_ext = CMPW'(count_ff);
   assign pos_ext   = CMPW'(pos_ff);
   assign pos_inc   = pos_ext + CMPW'(1);
   assign found_ext = FW'(found_ff);
   assign last_step = (idx_ff == end_ff);

   assign sts.kind     = kind_ff;
   assign sts.full     = (count_ff == CW'(DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.pos_gt   = (pos_ext > count_ext);
   assign sts.pos_ge   = (pos_ext >= count_ext);
   assign sts.walk     = walk_ff;
   assign sts.pend     = pend_ff;
   assign sts.match    = pend_ff && (rd_data == value_ff);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (cmd.mode)
         oat_pkg::WALK_INSERT: begin
            init_idx    = count_ff - CW'(1);
            init_end    = pos_ext[CW-1:0];
            init_walk   = (count_ext != pos_ext);
            init_dir_dn = 1'b1;
         end
         oat_pkg::WALK_DELETE: begin
            init_idx    = pos_inc[CW-1:0];
            init_end    = count_ff - CW'(1);
            init_walk   = (pos_inc != count_ext);
            init_dir_dn = 1'b0;
         end
         oat_pkg::WALK_SEARCH: begin
            init_idx    = '0;
            init_end    = count_ff - CW'(1);
            init_walk   = 1'b1;
            init_dir_dn = 1'b0;
         end
         default: begin
            init_idx    = pos_ext[CW-1:0];
            init_end    = pos_ext[CW-1:0];
            init_walk   = 1'b1;
            init_dir_dn = 1'b0;
         end
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      end_in    = end_ff;
      walk_in   = walk_ff;
      dir_dn_in = dir_dn_ff;
      if (cmd.init) begin
         idx_in    = init_idx;
         end_in    = init_end;
         walk_in   = init_walk;
         dir_dn_in = init_dir_dn;
      end else if (cmd.rd) begin
         walk_in = !last_step;
         if (!last_step) begin
            idx_in = dir_dn_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign wr_en   = cmd.shift_wr || cmd.put;
   assign wr_addr = cmd.put ? pos_ext[AW-1:0]
                  : (dir_dn_ff ? (pend_addr_ff + AW'(1)) : (pend_addr_ff - AW'(1)));
   assign wr_data = cmd.put ? value_ff : rd_data;

   oat_ram #(
      .WIDTH (oat_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         walk_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         walk_ff  <= walk_in;
         pend_ff  <= cmd.rd;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      end_ff    <= end_in;
      dir_dn_ff <= dir_dn_in;
      if (cmd.capture) begin
         kind_ff  <= req_tuser;
         pos_ff   <= req_tdata[oat_pkg::POS_W-1:0];
         value_ff <= req_tdata[oat_pkg::REQ_DATA_W-1:oat_pkg::POS_W];
      end
      if (cmd.rd) begin
         pend_addr_ff <= idx_ff[AW-1:0];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.res_clear) begin
         found_ff <= '0;
         rdval_ff <= '0;
      end
      if (cmd.take_found) begin
         found_ff <= pend_addr_ff;
      end
      if (cmd.take_read) begin
         rdval_ff <= rd_data;
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {1'b0, count_ext[oat_pkg::COUNT_W-1:0], rdval_ff,
                           found_ext[oat_pkg::FOUND_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== hdl/ordered_array_table_core.sv =====
`timescale 1ns / 1ps
// Clear and rejected requests go straight from the check to the response; a read fetches one entry.
// Insert shifts the entries from the last down to the position up by one, delete shifts those
// above the position down by one, and search scans from index 0 until a match: one entry per cycle.
// Throughput: one request at a time; the next is taken as soon as the response is queued.
// Reset (synchronous, active high) empties the table; entry storage is not cleared.
module ordered_array_table_core #(
   parameter int DEPTH = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [oat_pkg::REQ_DATA_W-1:0] req_tdata,  // position[7:0], value[39:8]
   input  logic [oat_pkg::KIND_W-1:0]     req_tuser,  // kind[2:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [oat_pkg::RSP_DATA_W-1:0] rsp_tdata,  // found_index[6:0], read_value[38:7],
                                                      // entry_count[46:39], zero[47]
   output logic [oat_pkg::STATUS_W-1:0]   rsp_tuser   // status[2:0]
);

   oat_pkg::dp_cmd_type cmd;
   oat_pkg::dp_sts_type sts;

   oat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   oat_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== hdl/oat_checker.sv =====
`timescale 1ns / 1ps

module oat_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [oat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [oat_pkg::STATUS_W-1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != oat_pkg::ST_OK) |-> (rsp_tdata[38:0] == '0))
      else $error("index or read value set on failed request");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind ordered_array_table_core oat_checker u_oat_checker (.*);
